// File: rtl/cascaded_pid_position_control_defines.svh
// ----------------------------------------------------------------------------
// Cascaded PID position control: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CASCADED_PID_POSITION_CONTROL_DEFINES_SVH
`define CASCADED_PID_POSITION_CONTROL_DEFINES_SVH

// Same-cycle implication.
`define CPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded PID position control: package
// Fixed-point constants, register indexes, command codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

	localparam int GAIN_FRACTION_BITS = 24;
	localparam int SH_POS             = GAIN_FRACTION_BITS - 16;
	localparam int SH_SPD             = GAIN_FRACTION_BITS;

	localparam logic [63:0] GAIN_ONE  = 64'd1 << GAIN_FRACTION_BITS;
	localparam logic [31:0] GAIN_C001 = 32'((GAIN_ONE + 64'd50) / 64'd100);
	localparam logic [31:0] GAIN_C01  = 32'((GAIN_ONE + 64'd5) / 64'd10);
	localparam logic [31:0] GAIN_C1   = 32'(GAIN_ONE);

	localparam logic [46:0] SSP_LIM   = 47'(1000 * 65536);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_POSITION_KP             = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_KI             = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_KD             = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_INTEGRAL_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT             = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP                = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI                = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_INTEGRAL_LIMIT    = 3'd7;

	localparam logic [31:0] RST_POSITION_KP             = 32'd8388608;
	localparam logic [31:0] RST_POSITION_KI             = 32'd25166;
	localparam logic [31:0] RST_POSITION_KD             = 32'd83886080;
	localparam logic [30:0] RST_POSITION_INTEGRAL_LIMIT = 31'd3000;
	localparam logic [14:0] RST_DRIVE_LIMIT             = 15'd8000;
	localparam logic [31:0] RST_SPEED_KP                = 32'd117440512;
	localparam logic [31:0] RST_SPEED_KI                = 32'd167772;
	localparam logic [30:0] RST_SPEED_INTEGRAL_LIMIT    = 31'd1500000;

	typedef struct packed {
		logic [31:0] position_kp;
		logic [31:0] position_ki;
		logic [31:0] position_kd;
		logic [30:0] position_integral_limit;
		logic [14:0] drive_limit;
		logic [31:0] speed_kp;
		logic [31:0] speed_ki;
		logic [30:0] speed_integral_limit;
	} cfg_t;

	typedef logic [1:0] opnd_sel_t;
	localparam opnd_sel_t OP_ERR  = 2'd0;
	localparam opnd_sel_t OP_SPD  = 2'd1;
	localparam opnd_sel_t OP_SERR = 2'd2;
	localparam opnd_sel_t OP_SINT = 2'd3;

	typedef logic [2:0] gain_sel_t;
	localparam gain_sel_t GK_I  = 3'd0;
	localparam gain_sel_t GK_P  = 3'd1;
	localparam gain_sel_t GK_D  = 3'd2;
	localparam gain_sel_t GK_SP = 3'd3;
	localparam gain_sel_t GK_SI = 3'd4;

	typedef logic [1:0] fin_sel_t;
	localparam fin_sel_t FIN_NONE = 2'd0;
	localparam fin_sel_t FIN_T0   = 2'd1;
	localparam fin_sel_t FIN_T1   = 2'd2;
	localparam fin_sel_t FIN_T2   = 2'd3;

	typedef struct packed {
		logic      capture;
		opnd_sel_t ld_opnd;
		gain_sel_t ld_gain;
		fin_sel_t  fin_dst;
		logic      pint_upd;
		logic      mix;
		logic      serr_upd;
		logic      sint_upd;
		logic      acc2;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic cascade;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/cpc_regs.sv
// ----------------------------------------------------------------------------
// Cascaded PID position control: configuration registers
// Gains and limits, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_regs
	import cpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.position_kp             <= RST_POSITION_KP;
			cfg_q.position_ki             <= RST_POSITION_KI;
			cfg_q.position_kd             <= RST_POSITION_KD;
			cfg_q.position_integral_limit <= RST_POSITION_INTEGRAL_LIMIT;
			cfg_q.drive_limit             <= RST_DRIVE_LIMIT;
			cfg_q.speed_kp                <= RST_SPEED_KP;
			cfg_q.speed_ki                <= RST_SPEED_KI;
			cfg_q.speed_integral_limit    <= RST_SPEED_INTEGRAL_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POSITION_KP:             cfg_q.position_kp <= cfg_data;
				REG_POSITION_KI:             cfg_q.position_ki <= cfg_data;
				REG_POSITION_KD:             cfg_q.position_kd <= cfg_data;
				REG_POSITION_INTEGRAL_LIMIT: cfg_q.position_integral_limit <= cfg_data[30:0];
				REG_DRIVE_LIMIT:             cfg_q.drive_limit <= cfg_data[14:0];
				REG_SPEED_KP:                cfg_q.speed_kp <= cfg_data;
				REG_SPEED_KI:                cfg_q.speed_ki <= cfg_data;
				REG_SPEED_INTEGRAL_LIMIT:    cfg_q.speed_integral_limit <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/cpc_dp.sv
// ----------------------------------------------------------------------------
// Cascaded PID position control: datapath
// Shared scaled-product pipeline, loop sums, clamps and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_dp
	import cpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  cfg_t               cfg,
	input  logic signed [31:0] target_position,
	input  logic signed [31:0] actual_position,
	input  logic signed [15:0] actual_speed,
	input  logic               cascade_on,
	output sts_t               sts,
	output logic signed [15:0] drive_current,
	output logic signed [10:0] speed_target
);

	function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
			input logic [46:0] lim);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = $signed({17'd0, lim});
		lo = 64'sd0 - hi;
		if (v > hi)
			return hi;
		else if (v < lo)
			return lo;
		else
			return v;
	endfunction

	logic signed [32:0] err_q;
	logic signed [15:0] spd_q;
	logic               casc_q;

	logic signed [47:0] pint_q;
	logic signed [47:0] sint_q;
	logic signed [26:0] ssp_q;
	logic signed [32:0] serr_q;
	logic signed [63:0] acc_q;
	logic signed [61:0] t0_q;
	logic signed [61:0] t1_q;
	logic signed [61:0] t2_q;

	logic signed [15:0] drive_current_q;
	logic signed [10:0] speed_target_q;

	logic [47:0] mag_s1;
	logic        neg_s1;
	logic [31:0] gain_s1;
	logic        shsel_s1;

	logic [63:0] plo_s2;
	logic [47:0] phi_s2;
	logic        neg_s2;
	logic        shsel_s2;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			err_q  <= {target_position[31], target_position}
				- {actual_position[31], actual_position};
			spd_q  <= actual_speed;
			casc_q <= cascade_on;
		end
	end

	assign sts.cascade = casc_q;

	logic signed [47:0] opnd;
	logic [47:0]        opnd_mag;
	logic [31:0]        gain;
	logic               shsel;

	always_comb begin
		case (cmd.ld_opnd)
			OP_ERR:  opnd = 48'(err_q);
			OP_SPD:  opnd = 48'(spd_q);
			OP_SERR: opnd = 48'(serr_q);
			OP_SINT: opnd = sint_q;
			default: opnd = '0;
		endcase
		opnd_mag = opnd[47] ? (~opnd + 48'd1) : opnd;
	end

	always_comb begin
		case (cmd.ld_gain)
			GK_I: begin
				gain  = casc_q ? GAIN_C001 : cfg.position_ki;
				shsel = 1'b0;
			end
			GK_P: begin
				gain  = casc_q ? GAIN_C01 : cfg.position_kp;
				shsel = 1'b0;
			end
			GK_D: begin
				gain  = casc_q ? GAIN_C1 : cfg.position_kd;
				shsel = 1'b0;
			end
			GK_SP: begin
				gain  = cfg.speed_kp;
				shsel = 1'b1;
			end
			GK_SI: begin
				gain  = cfg.speed_ki;
				shsel = 1'b1;
			end
			default: begin
				gain  = '0;
				shsel = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mag_s1   <= opnd_mag;
		neg_s1   <= opnd[47];
		gain_s1  <= gain;
		shsel_s1 <= shsel;
		plo_s2   <= 64'(mag_s1[31:0]) * 64'(gain_s1);
		phi_s2   <= 48'(mag_s1[47:32]) * 48'(gain_s1);
		neg_s2   <= neg_s1;
		shsel_s2 <= shsel_s1;
	end

	logic [48:0]        mid_sum;
	logic [80:0]        full;
	logic [80:0]        shifted;
	logic               big;
	logic [60:0]        term_mag;
	logic signed [61:0] term;

	always_comb begin
		mid_sum  = 49'(phi_s2) + 49'(plo_s2[63:32]);
		full     = {mid_sum, plo_s2[31:0]};
		shifted  = shsel_s2 ? (full >> SH_SPD) : (full >> SH_POS);
		big      = (|shifted[80:61]) || (shifted[60] && (|shifted[59:0]));
		term_mag = big ? (61'd1 << 60) : shifted[60:0];
		term     = neg_s2 ? (62'sd0 - $signed({1'b0, term_mag})) : $signed({1'b0, term_mag});
	end

	always_ff @(posedge clk) begin
		case (cmd.fin_dst)
			FIN_T0: t0_q <= term;
			FIN_T1: t1_q <= term;
			FIN_T2: t2_q <= term;
			default: begin
			end
		endcase
	end

	logic               band;
	logic signed [63:0] psum;
	logic signed [63:0] pclamp;
	logic signed [63:0] mix_sum;
	logic signed [63:0] sclamp_ssp;
	logic signed [31:0] spd_sh;
	logic signed [63:0] ssum;
	logic signed [63:0] sclamp;

	always_comb begin
		band       = (spd_q >= 16'sd1000) || (spd_q <= -16'sd1000);
		psum       = 64'(pint_q) + 64'(t0_q);
		pclamp     = clamp64(psum, {cfg.position_integral_limit, 16'h0000});
		mix_sum    = 64'(t1_q) + 64'(pint_q) - ((casc_q || band) ? 64'(t2_q) : 64'sd0);
		sclamp_ssp = clamp64(mix_sum, SSP_LIM);
		spd_sh     = {spd_q, 16'h0000};
		ssum       = 64'(sint_q) + 64'(serr_q);
		sclamp     = clamp64(ssum, {cfg.speed_integral_limit, 16'h0000});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pint_q <= '0;
			sint_q <= '0;
		end else begin
			if (cmd.pint_upd)
				pint_q <= pclamp[47:0];
			if (cmd.sint_upd)
				sint_q <= sclamp[47:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mix) begin
			acc_q <= mix_sum;
			ssp_q <= sclamp_ssp[26:0];
		end else if (cmd.acc2) begin
			acc_q <= 64'(t1_q) + 64'(t2_q);
		end
		if (cmd.serr_upd)
			serr_q <= 33'(ssp_q) - 33'(spd_sh);
	end

	logic signed [63:0] dclamp;
	logic signed [31:0] dc32;
	logic signed [31:0] drnd;
	logic signed [26:0] srnd;

	always_comb begin
		dclamp = clamp64(acc_q, {16'd0, cfg.drive_limit, 16'h0000});
		dc32   = dclamp[31:0];
		drnd   = dc32 + (dc32[31] ? 32'sd65535 : 32'sd0);
		srnd   = ssp_q + (ssp_q[26] ? 27'sd65535 : 27'sd0);
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			drive_current_q <= drnd[31:16];
			speed_target_q  <= casc_q ? srnd[26:16] : 11'sd0;
		end
	end

	assign drive_current = drive_current_q;
	assign speed_target  = speed_target_q;

endmodule

`default_nettype wire

// File: rtl/cpc_ctrl.sv
// ----------------------------------------------------------------------------
// Cascaded PID position control: controller
// Sequences product issues, loop updates and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cascaded_pid_position_control_defines.svh"

module cpc_ctrl
	import cpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic tick_valid,
	output logic tick_ready,
	output logic result_valid,
	input  logic result_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_P0    = 4'd1;
	localparam logic [3:0] S_P1    = 4'd2;
	localparam logic [3:0] S_P2    = 4'd3;
	localparam logic [3:0] S_P3    = 4'd4;
	localparam logic [3:0] S_P4    = 4'd5;
	localparam logic [3:0] S_MIX   = 4'd6;
	localparam logic [3:0] S_SERR  = 4'd7;
	localparam logic [3:0] S_SINT  = 4'd8;
	localparam logic [3:0] S_Q1    = 4'd9;
	localparam logic [3:0] S_Q2    = 4'd10;
	localparam logic [3:0] S_Q3    = 4'd11;
	localparam logic [3:0] S_ACC2  = 4'd12;
	localparam logic [3:0] S_CLAMP = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       result_valid_q;
	logic       can_load;

	assign tick_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign can_load     = !result_valid_q || result_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (tick_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_P0;
				end
			end
			S_P0: begin
				cmd.ld_opnd = OP_ERR;
				cmd.ld_gain = GK_I;
				state_d     = S_P1;
			end
			S_P1: begin
				cmd.ld_opnd = OP_ERR;
				cmd.ld_gain = GK_P;
				state_d     = S_P2;
			end
			S_P2: begin
				cmd.ld_opnd = OP_SPD;
				cmd.ld_gain = GK_D;
				cmd.fin_dst = FIN_T0;
				state_d     = S_P3;
			end
			S_P3: begin
				cmd.fin_dst  = FIN_T1;
				cmd.pint_upd = 1'b1;
				state_d      = S_P4;
			end
			S_P4: begin
				cmd.fin_dst = FIN_T2;
				state_d     = S_MIX;
			end
			S_MIX: begin
				cmd.mix = 1'b1;
				state_d = sts.cascade ? S_SERR : S_CLAMP;
			end
			S_SERR: begin
				cmd.serr_upd = 1'b1;
				state_d      = S_SINT;
			end
			S_SINT: begin
				cmd.sint_upd = 1'b1;
				cmd.ld_opnd  = OP_SERR;
				cmd.ld_gain  = GK_SP;
				state_d      = S_Q1;
			end
			S_Q1: begin
				cmd.ld_opnd = OP_SINT;
				cmd.ld_gain = GK_SI;
				state_d     = S_Q2;
			end
			S_Q2: begin
				cmd.fin_dst = FIN_T1;
				state_d     = S_Q3;
			end
			S_Q3: begin
				cmd.fin_dst = FIN_T2;
				state_d     = S_ACC2;
			end
			S_ACC2: begin
				cmd.acc2 = 1'b1;
				state_d  = S_CLAMP;
			end
			S_CLAMP: begin
				if (can_load) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	`CPC_ASSERT_NEXT(a_accept_starts, tick_valid && tick_ready, state_q == S_P0, "accepted transaction did not start the product sequence")
	`CPC_ASSERT_NOW(a_result_from_clamp, $rose(result_valid_q), $past(state_q) == S_CLAMP, "result raised outside the clamp step")
	`CPC_ASSERT_NOW(a_load_when_free, cmd.out_load, !result_valid_q || result_ready, "result register overwritten while held")
	`CPC_ASSERT_NOW(a_speed_loop_cascade, state_q == S_SERR || state_q == S_Q2, sts.cascade, "speed loop entered in direct mode")

endmodule

`default_nettype wire

// File: rtl/cascaded_pid_position_control.sv
// ----------------------------------------------------------------------------
// Cascaded PID position control: top level
// One drive command per control tick, direct PID or cascaded position/speed.
//
//   channel   signals                                        direction
//   tick      tick_valid/ready, target_position,             in
//             actual_position, actual_speed, cascade_on
//   result    result_valid/ready, drive_current,             out
//             speed_target
//   config    cfg_we, cfg_index, cfg_data                    in
//
// The result turns valid later in cascade mode than in direct mode, as the
// speed loop adds its own steps; the next tick is taken only after the result
// is loaded, so a new tick never overlaps the one in progress.
// The sequence is set by the single scaled-product pipeline (three stages, two
// partial products) whose results feed the dependent loop sums in order.
// Reset loads the default gains and limits and clears both integrals.
// A held result stalls the final load, and no new tick is taken until it is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_pid_position_control
	import cpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick_valid,
	output logic                  tick_ready,
	input  logic signed [31:0]    target_position,
	input  logic signed [31:0]    actual_position,
	input  logic signed [15:0]    actual_speed,
	input  logic                  cascade_on,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic signed [15:0]    drive_current,
	output logic signed [10:0]    speed_target,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	cpc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cpc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	cpc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg),
		.target_position (target_position),
		.actual_position (actual_position),
		.actual_speed    (actual_speed),
		.cascade_on      (cascade_on),
		.sts             (sts),
		.drive_current   (drive_current),
		.speed_target    (speed_target)
	);

endmodule

`default_nettype wire

// File: verif/cascaded_pid_position_control_test.sv
// ----------------------------------------------------------------------------
// Cascaded PID position control: testbench
// Drives control ticks through the valid/ready tick channel and checks every
// drive command against a cycle-free fixed-point controller kept alongside.
// Directed ticks cover error and speed extremes, the damping band edges and
// mode changes; random ticks run under several gain and limit settings with
// random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_pid_position_control_test
	import cpc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          FRAC         = GAIN_FRACTION_BITS;
	localparam int          POS_SHIFT    = FRAC - 16;
	localparam int          SPD_SHIFT    = FRAC;
	localparam longint      UNITY        = longint'(1) << FRAC;
	localparam logic [31:0] K_HUNDREDTH  = 32'((UNITY + 50) / 100);
	localparam logic [31:0] K_TENTH      = 32'((UNITY + 5) / 10);
	localparam logic [31:0] K_UNITY      = 32'(UNITY);
	localparam longint      SETPOINT_MAX = longint'(1000) * 65536;
	localparam longint      DAMP_BAND    = 1000;
	localparam longint      SAT_LEVEL    = longint'(1) << 60;
	localparam int          ITEMS_PER_PHASE = 80;
	localparam int          NUM_PHASES   = 6;
	localparam int          SETTLE_CYCLES = 24;
	localparam int          QUIET_LIMIT  = 4000;
	localparam int          HOLD_OFF     = 300;

	typedef struct {
		logic signed [31:0] target;
		logic signed [31:0] actual;
		logic signed [15:0] speed;
		logic               cascade;
	} tick_t;

	typedef struct {
		logic signed [15:0] drive;
		logic signed [10:0] setpoint;
	} command_t;

	logic                  clk;
	logic                  arst_n          = 1'b0;
	logic                  tick_valid      = 1'b0;
	logic                  tick_ready;
	logic signed [31:0]    target_position = '0;
	logic signed [31:0]    actual_position = '0;
	logic signed [15:0]    actual_speed    = '0;
	logic                  cascade_on      = 1'b0;
	logic                  result_valid;
	logic                  result_ready    = 1'b0;
	logic signed [15:0]    drive_current;
	logic signed [10:0]    speed_target;
	logic                  cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index       = '0;
	logic [CFG_DATA_W-1:0] cfg_data        = '0;

	cascaded_pid_position_control u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick_valid      (tick_valid),
		.tick_ready      (tick_ready),
		.target_position (target_position),
		.actual_position (actual_position),
		.actual_speed    (actual_speed),
		.cascade_on      (cascade_on),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.drive_current   (drive_current),
		.speed_target    (speed_target),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	cfg_t     loop_cfg;
	longint   pos_integral;
	longint   spd_integral;
	tick_t    tick_backlog[$];
	command_t cmd_expected[$];
	int       tx_idle_pct   = 31;
	int       rx_idle_pct   = 85;
	int       mismatches    = 0;
	int       commands_seen = 0;
	int       hold_left     = 0;
	bit       held_once     = 1'b0;
	bit       run_cascade   = 1'b0;
	int       quiet_cycles  = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint scaled(longint v, logic [31:0] gain, int sh);
		logic [127:0] mag;
		logic [127:0] prod;
		longint       r;
		mag  = (v < 0) ? 128'(-v) : 128'(v);
		prod = (mag * {96'd0, gain}) >> sh;
		if (prod > 128'(SAT_LEVEL))
			prod = 128'(SAT_LEVEL);
		r = longint'(prod[63:0]);
		return (v < 0) ? -r : r;
	endfunction

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint toward_zero16(longint v);
		if (v < 0)
			return -((-v) >>> 16);
		return v >>> 16;
	endfunction

	function automatic command_t run_controller(tick_t t);
		longint   err;
		longint   spd;
		longint   plim;
		longint   slim;
		longint   dlim;
		longint   acc;
		longint   ssp;
		longint   serr;
		command_t c;
		err  = longint'(t.target) - longint'(t.actual);
		spd  = longint'(t.speed);
		plim = longint'(loop_cfg.position_integral_limit) * 65536;
		slim = longint'(loop_cfg.speed_integral_limit) * 65536;
		dlim = longint'(loop_cfg.drive_limit) * 65536;
		c.setpoint = '0;
		if (!t.cascade) begin
			pos_integral = clamp_sym(pos_integral
				+ scaled(err, loop_cfg.position_ki, POS_SHIFT), plim);
			acc = scaled(err, loop_cfg.position_kp, POS_SHIFT) + pos_integral;
			if (spd >= DAMP_BAND || spd <= -DAMP_BAND)
				acc -= scaled(spd, loop_cfg.position_kd, POS_SHIFT);
		end else begin
			pos_integral = clamp_sym(pos_integral
				+ scaled(err, K_HUNDREDTH, POS_SHIFT), plim);
			ssp = scaled(err, K_TENTH, POS_SHIFT) + pos_integral
				- scaled(spd, K_UNITY, POS_SHIFT);
			ssp = clamp_sym(ssp, SETPOINT_MAX);
			c.setpoint = 11'(toward_zero16(ssp));
			serr = ssp - spd * 65536;
			spd_integral = clamp_sym(spd_integral + serr, slim);
			acc = scaled(serr, loop_cfg.speed_kp, SPD_SHIFT)
				+ scaled(spd_integral, loop_cfg.speed_ki, SPD_SHIFT);
		end
		c.drive = 16'(toward_zero16(clamp_sym(acc, dlim)));
		return c;
	endfunction

	task automatic note_mismatch(string msg);
		if (mismatches < 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_POSITION_KP:             loop_cfg.position_kp = val;
			REG_POSITION_KI:             loop_cfg.position_ki = val;
			REG_POSITION_KD:             loop_cfg.position_kd = val;
			REG_POSITION_INTEGRAL_LIMIT: loop_cfg.position_integral_limit = val[30:0];
			REG_DRIVE_LIMIT:             loop_cfg.drive_limit = val[14:0];
			REG_SPEED_KP:                loop_cfg.speed_kp = val;
			REG_SPEED_KI:                loop_cfg.speed_ki = val;
			REG_SPEED_INTEGRAL_LIMIT:    loop_cfg.speed_integral_limit = val[30:0];
			default: ;
		endcase
	endtask

	task automatic program_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
		logic [31:0] pil, logic [31:0] dl, logic [31:0] skp, logic [31:0] ski,
		logic [31:0] sil);
		write_reg(REG_POSITION_KP, kp);
		write_reg(REG_POSITION_KI, ki);
		write_reg(REG_POSITION_KD, kd);
		write_reg(REG_POSITION_INTEGRAL_LIMIT, pil);
		write_reg(REG_DRIVE_LIMIT, dl);
		write_reg(REG_SPEED_KP, skp);
		write_reg(REG_SPEED_KI, ski);
		write_reg(REG_SPEED_INTEGRAL_LIMIT, sil);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_tick(int tgt, int act, int spd, bit casc);
		tick_t t;
		t.target  = tgt;
		t.actual  = act;
		t.speed   = 16'(spd);
		t.cascade = casc;
		tick_backlog.push_back(t);
	endtask

	task automatic queue_directed();
		push_tick(0, 0, 0, 1'b0);
		push_tick(1000, 0, 0, 1'b0);
		push_tick(-1000, 0, 999, 1'b0);
		push_tick(0, 0, -999, 1'b0);
		push_tick(0, 0, 1000, 1'b0);
		push_tick(0, 0, -1000, 1'b0);
		push_tick(32'h7FFF_FFFF, 32'h8000_0000, 32767, 1'b0);
		push_tick(32'h8000_0000, 32'h7FFF_FFFF, -32768, 1'b0);
		push_tick(500, 0, 0, 1'b1);
		push_tick(0, 0, 1000, 1'b1);
		push_tick(32'h7FFF_FFFF, 32'h8000_0000, -32768, 1'b1);
		push_tick(32'h8000_0000, 32'h7FFF_FFFF, 32767, 1'b1);
		push_tick(0, 0, 0, 1'b1);
		push_tick(0, 0, 0, 1'b1);
		push_tick(100000, 0, 200, 1'b1);
		push_tick(-100000, 0, -200, 1'b1);
		push_tick(0, 0, 0, 1'b0);
		push_tick(50, 60, -1, 1'b0);
	endtask

	task automatic queue_random(int count);
		tick_t t;
		int    kind;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(7) == 0)
				run_cascade = ~run_cascade;
			kind     = $urandom_range(9);
			t.actual = $urandom;
			if (kind < 6)
				t.target = t.actual + (int'($urandom_range(4000)) - 2000);
			else if (kind < 8)
				t.target = t.actual + (int'($urandom_range(2000000)) - 1000000);
			else
				t.target = $urandom;
			kind = $urandom_range(9);
			if (kind < 7)
				t.speed = 16'(int'($urandom_range(4000)) - 2000);
			else if (kind < 9)
				t.speed = 16'($urandom);
			else
				t.speed = ($urandom_range(1)) ? 16'(999 + $urandom_range(1))
					: 16'(-999 - int'($urandom_range(1)));
			t.cascade = ($urandom_range(19) == 0) ? ~run_cascade : run_cascade;
			tick_backlog.push_back(t);
		end
	endtask

	task automatic wait_drained();
		while (tick_backlog.size() != 0 || tick_valid || cmd_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : tick_driver
		tick_t nxt;
		if (!arst_n) begin
			tick_valid      <= 1'b0;
			target_position <= '0;
			actual_position <= '0;
			actual_speed    <= '0;
			cascade_on      <= 1'b0;
		end else begin
			if (tick_valid && tick_ready)
				cmd_expected.push_back(run_controller(tick_t'{target_position,
					actual_position, actual_speed, cascade_on}));
			if (!tick_valid || tick_ready) begin
				if (tick_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = tick_backlog.pop_front();
					tick_valid      <= 1'b1;
					target_position <= nxt.target;
					actual_position <= nxt.actual;
					actual_speed    <= nxt.speed;
					cascade_on      <= nxt.cascade;
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : command_sink
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (!held_once && commands_seen >= 40) begin
			held_once = 1'b1;
			hold_left = HOLD_OFF;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : command_monitor
		command_t want;
		if (arst_n && result_valid && result_ready) begin
			commands_seen++;
			if (cmd_expected.size() == 0) begin
				note_mismatch($sformatf("unexpected command drive=%0d speed_target=%0d",
					drive_current, speed_target));
			end else begin
				want = cmd_expected.pop_front();
				if (drive_current !== want.drive)
					note_mismatch($sformatf("drive_current expected %0d got %0d",
						want.drive, drive_current));
				if (speed_target !== want.setpoint)
					note_mismatch($sformatf("speed_target expected %0d got %0d",
						want.setpoint, speed_target));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((tick_valid && tick_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		loop_cfg.position_kp             = 32'd8388608;
		loop_cfg.position_ki             = 32'd25166;
		loop_cfg.position_kd             = 32'd83886080;
		loop_cfg.position_integral_limit = 31'd3000;
		loop_cfg.drive_limit             = 15'd8000;
		loop_cfg.speed_kp                = 32'd117440512;
		loop_cfg.speed_ki                = 32'd167772;
		loop_cfg.speed_integral_limit    = 31'd1500000;
		pos_integral = 0;
		spd_integral = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase < 2) begin
				tx_idle_pct = 31;
				rx_idle_pct = 85;
			end else if (phase < 4) begin
				tx_idle_pct = 85;
				rx_idle_pct = 31;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (phase)
				0: queue_directed();
				1: program_all('1, '1, '1, '1, '1, '1, '1, '1);
				2: program_all('0, '0, '0, '0, '0, '0, '0, '0);
				3: program_all($urandom_range(1 << 26), $urandom_range(1 << 20),
					$urandom_range(1 << 26), $urandom_range(100000) | 32'h8000_0000,
					$urandom_range(32767) | 32'hFFFF_8000, $urandom_range(1 << 28),
					$urandom_range(1 << 20), $urandom_range(2000000));
				4: program_all($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
				default: program_all(32'd1, '1, 32'd1 << FRAC, 32'd1, 32'd32767,
					32'd1 << FRAC, '1, 32'h7FFF_FFFF);
			endcase
			queue_random(ITEMS_PER_PHASE);
			wait_drained();
		end
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/cpc_pkg.sv
rtl/cpc_regs.sv
rtl/cpc_dp.sv
rtl/cpc_ctrl.sv
rtl/cascaded_pid_position_control.sv
verif/cascaded_pid_position_control_test.sv
